@@ rtl/core/drrb_pkg.sv @@
// descending run release buffer: shared types
// no dependencies
`default_nettype none

package drrb_pkg;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_INC   = 4'b0100,
        ST_REL   = 4'b1000
    } state_t;

endpackage

`default_nettype wire

@@ rtl/core/drrb_ram.sv @@
// generic single write port ram with one registered read port
// no dependencies
`default_nettype none

module drrb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/core/descending_run_release_buffer.sv @@
// descending run release buffer: top level, count store sequencer
// depends on drrb_pkg and drrb_ram
`default_nettype none

// a request is taken in idle and its count updated in the increment state; unless the
// expectation is zero, release steps follow, one key each, until the count at the
// expectation is zero or key one is released; no new request is taken until then
// reset: expectation cleared, then a clearing pass over all 2^KEY_BITS entries zeroes
// the count store with busy high; configuration writes are taken during it
// results cannot be stalled and appear for exactly one cycle
module descending_run_release_buffer #(
    parameter int KEY_BITS   = 10,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [KEY_BITS-1:0] arriving_key,
    input  wire logic                cfg_we,
    input  wire logic [KEY_BITS-1:0] start_expectation,
    output logic                     result_valid,
    output logic      [KEY_BITS-1:0] first_released,
    output logic      [KEY_BITS-1:0] released_count
);

    localparam int DEPTH = 1 << KEY_BITS;

    drrb_pkg::state_t state_reg, state_next;

    logic [KEY_BITS-1:0]   clr_reg, clr_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [KEY_BITS-1:0]   exp_reg, exp_next;
    logic [KEY_BITS-1:0]   first_reg, first_next;
    logic [KEY_BITS-1:0]   run_reg, run_next;
    logic                  valid_reg, valid_next;
    logic                  fwd_reg, fwd_next;
    logic [COUNT_BITS-1:0] fwd_data_reg, fwd_data_next;

    logic                  ram_we;
    logic [KEY_BITS-1:0]   ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;
    logic [KEY_BITS-1:0]   ram_raddr;
    logic [COUNT_BITS-1:0] ram_rdata;

    logic [COUNT_BITS-1:0] inc_count;
    logic [COUNT_BITS-1:0] cur_count;

    drrb_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_count_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // saturating increment of the arriving key's count
    assign inc_count = (&ram_rdata) ? ram_rdata : ram_rdata + COUNT_BITS'(1);
    // count at the expectation, forwarded when it was written in the same cycle as read
    assign cur_count = fwd_reg ? fwd_data_reg : ram_rdata;

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        key_next      = key_reg;
        exp_next      = exp_reg;
        first_next    = first_reg;
        run_next      = run_reg;
        valid_next    = 1'b0;
        fwd_next      = 1'b0;
        fwd_data_next = fwd_data_reg;
        ram_we        = 1'b0;
        ram_waddr     = key_reg;
        ram_wdata     = '0;
        ram_raddr     = exp_reg;

        case (state_reg)
            drrb_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + KEY_BITS'(1);
                if (&clr_reg)
                begin
                    state_next = drrb_pkg::ST_IDLE;
                end
            end
            drrb_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    key_next   = arriving_key;
                    ram_raddr  = arriving_key;
                    state_next = drrb_pkg::ST_INC;
                end
            end
            drrb_pkg::ST_INC:
            begin
                ram_we        = 1'b1;
                ram_waddr     = key_reg;
                ram_wdata     = inc_count;
                first_next    = exp_reg;
                run_next      = '0;
                fwd_next      = (key_reg == exp_reg);
                fwd_data_next = inc_count;
                ram_raddr     = exp_reg;
                if (exp_reg == '0)
                begin
                    valid_next = 1'b1;
                    state_next = drrb_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = drrb_pkg::ST_REL;
                end
            end
            drrb_pkg::ST_REL:
            begin
                if (cur_count == '0)
                begin
                    valid_next = 1'b1;
                    state_next = drrb_pkg::ST_IDLE;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = exp_reg;
                    ram_wdata = cur_count - COUNT_BITS'(1);
                    exp_next  = exp_reg - KEY_BITS'(1);
                    run_next  = run_reg + KEY_BITS'(1);
                    ram_raddr = exp_reg - KEY_BITS'(1);
                    if (exp_reg == KEY_BITS'(1))
                    begin
                        valid_next = 1'b1;
                        state_next = drrb_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = drrb_pkg::ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            exp_next = start_expectation;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= drrb_pkg::ST_CLEAR;
            clr_reg   <= '0;
            exp_reg   <= '0;
            valid_reg <= 1'b0;
            fwd_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            exp_reg   <= exp_next;
            valid_reg <= valid_next;
            fwd_reg   <= fwd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        first_reg    <= first_next;
        run_reg      <= run_next;
        fwd_data_reg <= fwd_data_next;
    end

    assign busy           = (state_reg != drrb_pkg::ST_IDLE);
    assign result_valid   = valid_reg;
    assign first_released = first_reg;
    assign released_count = run_reg;

    // results never come in consecutive cycles
    a_result_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("back to back result strobes");

    // a run cannot release more keys than the expectation it started from
    a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (released_count <= first_released))
        else $error("run longer than start expectation");

    // release never continues from an expectation of zero
    a_rel_exp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == drrb_pkg::ST_REL) |-> (exp_reg != '0))
        else $error("release step with zero expectation");

    // an accepted request goes straight to the count update
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == drrb_pkg::ST_INC))
        else $error("accepted request not processed");

endmodule

`default_nettype wire

@@ tb/sv/tb_descending_run_release_buffer.sv @@
// testbench for descending_run_release_buffer: directed and random requests,
// each result checked against a local model of the count store and expectation
// depends on rtl/core/drrb_pkg.sv, drrb_ram.sv and descending_run_release_buffer.sv
module tb_descending_run_release_buffer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_BITS    = 10;
    localparam int COUNT_BITS  = 16;
    localparam int KEY_SPAN    = 1 << KEY_BITS;
    localparam int KEY_TOP     = KEY_SPAN - 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int TAIL_CYCLES = KEY_SPAN + 8;
    localparam int REPORT_MAX  = 10;
    localparam int RANDOM_PHASES = 26;

    typedef logic [KEY_BITS-1:0] key_t;
    typedef struct packed {
        key_t top_key;
        key_t run_length;
    } run_report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    key_t arriving_key = '0;
    logic cfg_we = 1'b0;
    key_t start_expectation = '0;
    logic busy;
    logic result_valid;
    key_t first_released;
    key_t released_count;

    logic [COUNT_BITS-1:0] key_tally [KEY_SPAN];
    key_t next_key;
    key_t key_queue[$];
    run_report_t pending_runs[$];
    run_report_t wanted;
    int idle_pct = 0;
    int requests_sent = 0;
    int settings_used = 0;
    int longest_run = 0;
    int mismatches = 0;
    int cycle_count = 0;

    descending_run_release_buffer #(
        .KEY_BITS   (KEY_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .arriving_key      (arriving_key),
        .cfg_we            (cfg_we),
        .start_expectation (start_expectation),
        .result_valid      (result_valid),
        .first_released    (first_released),
        .released_count    (released_count)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    // count the arrival, then release downward while the expected key is present
    function automatic run_report_t predict_run(input key_t key);
        run_report_t rpt;
        if (key_tally[key] != COUNT_MAX)
            key_tally[key] = key_tally[key] + 1'b1;
        rpt.top_key    = next_key;
        rpt.run_length = '0;
        while (next_key != '0 && key_tally[next_key] != '0)
        begin
            key_tally[next_key] = key_tally[next_key] - 1'b1;
            next_key = next_key - 1'b1;
            rpt.run_length = rpt.run_length + 1'b1;
        end
        if (int'(rpt.run_length) > longest_run)
            longest_run = int'(rpt.run_length);
        return rpt;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            arriving_key <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                pending_runs.push_back(predict_run(arriving_key));
                requests_sent++;
            end
            if (!start || !busy)
            begin
                if (key_queue.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    start <= 1'b1;
                    arriving_key <= key_queue.pop_front();
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (pending_runs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result: first %0d count %0d",
                             first_released, released_count);
            end
            else
            begin
                wanted = pending_runs.pop_front();
                if (wanted.top_key !== first_released || wanted.run_length !== released_count)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("mismatch: first %0d (expected %0d) count %0d (expected %0d)",
                                 first_released, wanted.top_key,
                                 released_count, wanted.run_length);
                end
            end
        end
    end

    task automatic wait_drained();
        do
            @(posedge clk);
        while (key_queue.size() != 0 || start || pending_runs.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_expectation(input int value);
        @(posedge clk);
        cfg_we <= 1'b1;
        start_expectation <= key_t'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        next_key = key_t'(value);
        settings_used++;
    endtask

    function automatic key_t noise_key(input int top);
        case ($urandom_range(3))
            0: return key_t'($urandom_range(KEY_TOP));
            1: return '0;
            2: return (top < KEY_TOP) ? key_t'($urandom_range(KEY_TOP, top + 1))
                                      : key_t'($urandom_range(KEY_TOP));
            default: return key_t'($urandom_range(top > 0 ? top : 1, 1));
        endcase
    endfunction

    // keys top downward, locally shuffled within a window, optionally one missing, noise keys mixed in
    task automatic queue_descending_run(input int top, input int span, input int win,
                                        input int noise_pct, input bit drop);
        int keys[$];
        int j;
        int tmp;
        for (int k = 0; k < span; k++)
            keys.push_back(top - k);
        if (drop && span > 2)
            keys.delete($urandom_range(span - 2, 1));
        for (int k = keys.size() - 1; k > 0; k--)
        begin
            j = k - $urandom_range(k < win ? k : win);
            tmp = keys[k];
            keys[k] = keys[j];
            keys[j] = tmp;
        end
        foreach (keys[k])
        begin
            if ($urandom_range(99) < noise_pct)
                key_queue.push_back(noise_key(top));
            key_queue.push_back(key_t'(keys[k]));
        end
    endtask

    initial
    begin
        int top;
        int span;
        for (int k = 0; k < KEY_SPAN; k++)
            key_tally[k] = '0;
        next_key = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        while (busy)
            @(posedge clk);

        // expectation zero: nothing released, key zero and top key counted
        key_queue.push_back(key_t'(0));
        key_queue.push_back(key_t'(KEY_TOP));
        key_queue.push_back(key_t'(5));
        key_queue.push_back(key_t'(5));
        key_queue.push_back(key_t'(1));
        wait_drained();

        load_expectation(3);
        key_queue.push_back(key_t'(1));
        key_queue.push_back(key_t'(2));
        key_queue.push_back(key_t'(3));
        key_queue.push_back(key_t'(0));
        wait_drained();

        load_expectation(KEY_TOP);
        key_queue.push_back(key_t'(KEY_TOP));
        key_queue.push_back(key_t'(KEY_TOP - 1));
        wait_drained();

        // key above the expectation stays counted
        load_expectation(10);
        key_queue.push_back(key_t'(20));
        for (int k = 10; k >= 6; k--)
            key_queue.push_back(key_t'(k));
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p % 4)
                1: idle_pct = 73;
                3: idle_pct = 36;
                default: idle_pct = 0;
            endcase
            if (p == 5 || p == 12)
            begin
                load_expectation($urandom_range(KEY_TOP));
                for (int k = 0; k < 100; k++)
                    key_queue.push_back(key_t'($urandom_range(KEY_TOP)));
            end
            else
            begin
                top = (p % 3 == 0) ? $urandom_range(KEY_TOP, 1) : $urandom_range(48, 1);
                span = $urandom_range(top < 90 ? top : 90, 1);
                load_expectation(top);
                queue_descending_run(top, span, $urandom_range(span), 15, p % 5 == 4);
            end
            wait_drained();
        end

        // near-full descending run
        idle_pct = 0;
        load_expectation(KEY_TOP);
        queue_descending_run(KEY_TOP - 2, KEY_TOP - 2, KEY_TOP, 0, 1'b0);
        key_queue.push_back(key_t'(KEY_TOP - 1));
        key_queue.push_back(key_t'(KEY_TOP));
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_runs.size() != 0)
        begin
            $display("%0d requests left without a result", pending_runs.size());
            mismatches += pending_runs.size();
        end
        $display("%0d requests over %0d expectation settings, longest run %0d keys",
                 requests_sent, settings_used, longest_run);
        $display("sender pauses of 0/36/73 in 100, zero and out-of-range keys, full-depth run");
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
